// File: design/kwm_pkg.sv
// Package for the k-way sorted stream merge: sizes and the request and
// result payload structs. No dependencies.
`default_nettype none
package kwm_pkg;
   localparam int NUM_STREAMS  = 8;
   localparam int FIFO_DEPTH   = 4;
   localparam int KEY_BITS     = 64;
   localparam int PAYLOAD_BITS = 32;
   localparam int SID_W   = 3;
   localparam int PTR_W   = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
   localparam int CNT_W   = $clog2(FIFO_DEPTH + 1);
   localparam int SLOT_W  = $clog2(NUM_STREAMS * FIFO_DEPTH);
   localparam int ACT_W   = 4;
   localparam int ENTRY_W = KEY_BITS + PAYLOAD_BITS;

   typedef struct packed {
      logic [2:0]  stream_id;
      logic        end_of_stream;
      logic [63:0] order_key;
      logic [31:0] payload;
   } req_type;

   typedef struct packed {
      logic [2:0]  out_stream;
      logic [63:0] out_key;
      logic [31:0] out_payload;
      logic        is_last;
      logic        overflowed;
   } rsp_type;
endpackage
`default_nettype wire

// File: design/kwm_if.sv
// Valid/ready channel interface carrying one request or result payload.
// Depends on kwm_pkg.
`default_nettype none
interface kwm_req_if;
   logic              valid;
   logic              ready;
   kwm_pkg::req_type  data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

interface kwm_rsp_if;
   logic              valid;
   logic              ready;
   kwm_pkg::rsp_type  data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// File: design/kwm_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module kwm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]              rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end
endmodule
`default_nettype wire

// File: design/k_way_sorted_stream_merge.sv
// k-way sorted stream merge: the first result a request releases is registered
// in the evaluate state after the accept; each further result follows a pop and an evaluate.
// A request holds the input through accept and evaluate, plus an evaluate and a
// pop per popped element (evaluate, read the winner's entry into the hold register);
// the end-of-merge flush happens in the closing evaluate cycle.
// Evaluation waits while the output register holds an unaccepted result.
// Heads of all streams are kept in flip-flops, so selection is a compare tree.
// Reset (synchronous, active high) clears counters, flags and the hold stage.
`default_nettype none
module k_way_sorted_stream_merge (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_wr_en,
   input  wire logic [3:0]            csr_wr_data,
   kwm_req_if.sink                    req,
   kwm_rsp_if.source                  rsp
);
   import kwm_pkg::*;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_EVAL = 2'd1;
   localparam logic [1:0] ST_POP  = 2'd2;

   logic [1:0]             state_ff, state_in;
   logic [ACT_W-1:0]       active_ff;
   logic [CNT_W-1:0]       fill_ff  [NUM_STREAMS];
   logic [PTR_W-1:0]       rdp_ff   [NUM_STREAMS];
   logic [PTR_W-1:0]       wrp_ff   [NUM_STREAMS];
   logic [NUM_STREAMS-1:0] ended_ff;
   logic [KEY_BITS-1:0]    headkey_ff [NUM_STREAMS];
   logic                   ovf_ff, fin_ff;
   logic                   hold_v_ff;
   logic [SID_W-1:0]       pop_sid_ff;
   logic [SLOT_W-1:0]      wr_slot;
   logic [SLOT_W-1:0]      rd_slot;
   logic                   ram_we;
   logic [ENTRY_W-1:0]     ram_q;
   logic                   rsp_v_ff;
   rsp_type                rsp_ff;
   logic [ACT_W-1:0]       lim;
   logic                   blocked, found;
   logic [SID_W-1:0]       best;
   logic [KEY_BITS-1:0]    best_key;
   logic                   accept;
   logic [SID_W-1:0]       sid;
   logic                   take;
   logic [CNT_W-1:0]       fill_sid;
   logic [PTR_W-1:0]       wrp_sid;
   logic [SID_W-1:0]       hold_sid_ff;
   logic [ENTRY_W-1:0]     hold_ent_ff;
   logic                   ev_go;
   logic                   refresh_ff;
   logic [SID_W-1:0]       refresh_sid_ff;
   logic [ENTRY_W-1:0]     head_q;
   logic [SLOT_W-1:0]      head_slot;

   // clamp the live stream count to 1..NUM_STREAMS
   always_comb begin
      if (active_ff == '0) begin
         lim = ACT_W'(1);
      end else if (active_ff > ACT_W'(NUM_STREAMS)) begin
         lim = ACT_W'(NUM_STREAMS);
      end else begin
         lim = active_ff;
      end
   end

   assign accept   = req.valid && req.ready;
   assign sid      = req.data.stream_id;
   assign fill_sid = fill_ff[sid];
   assign wrp_sid  = wrp_ff[sid];
   // an element goes in only for a live, open stream with room
   assign take = accept && !fin_ff && ({1'b0, sid} < lim) && !ended_ff[sid]
                 && !req.data.end_of_stream && (fill_sid < CNT_W'(FIFO_DEPTH));
   assign ram_we  = take;
   assign wr_slot = SLOT_W'(sid) * SLOT_W'(FIFO_DEPTH) + SLOT_W'(wrp_sid);
   assign rd_slot = SLOT_W'(best) * SLOT_W'(FIFO_DEPTH) + SLOT_W'(rdp_ff[best]);

   kwm_ram #(.WIDTH(ENTRY_W), .DEPTH(NUM_STREAMS * FIFO_DEPTH)) u_entries (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (wr_slot),
      .wr_data ({req.data.order_key[KEY_BITS-1:0], req.data.payload[PAYLOAD_BITS-1:0]}),
      .rd_addr (rd_slot),
      .rd_data (ram_q)
   );

   // head keys live in flip-flops; pick the smallest, lower stream on ties.
   // Right after a pop the popped stream's new head comes from the RAM output.
   always_comb begin
      logic [KEY_BITS-1:0] key_s;
      blocked  = 1'b0;
      found    = 1'b0;
      best     = '0;
      best_key = '0;
      key_s    = '0;
      for (int s = 0; s < NUM_STREAMS; s++) begin
         if (refresh_ff && refresh_sid_ff == SID_W'(s)) begin
            key_s = head_q[ENTRY_W-1 -: KEY_BITS];
         end else begin
            key_s = headkey_ff[s];
         end
         if (ACT_W'(s) < lim) begin
            if (!ended_ff[s] && fill_ff[s] == '0) begin
               blocked = 1'b1;
            end
            if (fill_ff[s] != '0 && (!found || key_s < best_key)) begin
               found    = 1'b1;
               best     = SID_W'(s);
               best_key = key_s;
            end
         end
      end
   end

   assign req.ready = (state_ff == ST_IDLE);
   assign rsp.valid = rsp_v_ff;
   assign rsp.data  = rsp_ff;

   // evaluate only with a free output slot
   assign ev_go = (state_ff == ST_EVAL) && !fin_ff && !blocked && (!rsp_v_ff || rsp.ready);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_EVAL;
            end
         end
         ST_EVAL: begin
            // wait for a free output slot before emitting anything
            if (fin_ff || blocked) begin
               state_in = ST_IDLE;
            end else if (!rsp_v_ff || rsp.ready) begin
               state_in = found ? ST_POP : ST_IDLE;
            end
         end
         ST_POP:  state_in = ST_EVAL;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         active_ff <= ACT_W'(8);
         ended_ff  <= '0;
         ovf_ff    <= 1'b0;
         fin_ff    <= 1'b0;
         hold_v_ff <= 1'b0;
         rsp_v_ff  <= 1'b0;
         for (int s = 0; s < NUM_STREAMS; s++) begin
            fill_ff[s] <= '0;
            rdp_ff[s]  <= '0;
            wrp_ff[s]  <= '0;
         end
      end else begin
         state_ff <= state_in;
         if (csr_wr_en) begin
            active_ff <= csr_wr_data;
         end
         // drop the valid once taken, unless a new result replaces it
         if (rsp_v_ff && rsp.ready && !(ev_go && hold_v_ff)) begin
            rsp_v_ff <= 1'b0;
         end
         if (accept && !fin_ff && ({1'b0, sid} < lim) && !ended_ff[sid]) begin
            if (req.data.end_of_stream) begin
               ended_ff[sid] <= 1'b1;
            end else if (fill_sid >= CNT_W'(FIFO_DEPTH)) begin
               ovf_ff <= 1'b1;
            end
         end
         if (take) begin
            fill_ff[sid] <= fill_sid + CNT_W'(1);
            wrp_ff[sid]  <= (wrp_sid == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wrp_sid + PTR_W'(1);
            // an empty FIFO gets its head key straight from the request
            if (fill_sid == '0) begin
               headkey_ff[sid] <= req.data.order_key[KEY_BITS-1:0];
            end
         end
         // store the refreshed head key of the stream popped last
         if (refresh_ff) begin
            headkey_ff[refresh_sid_ff] <= head_q[ENTRY_W-1 -: KEY_BITS];
         end
         if (ev_go) begin
            if (found) begin
               // RAM read of the winner is under way; advance its pointer
               pop_sid_ff    <= best;
               fill_ff[best] <= fill_ff[best] - CNT_W'(1);
               rdp_ff[best]  <= (rdp_ff[best] == PTR_W'(FIFO_DEPTH - 1)) ? '0
                                : rdp_ff[best] + PTR_W'(1);
               if (hold_v_ff) begin
                  rsp_v_ff <= 1'b1;
                  rsp_ff   <= '{out_stream: hold_sid_ff,
                                out_key: hold_ent_ff[ENTRY_W-1 -: KEY_BITS],
                                out_payload: hold_ent_ff[PAYLOAD_BITS-1:0],
                                is_last: 1'b0, overflowed: ovf_ff};
               end
            end else begin
               // all streams ended and drained: flush hold as last
               fin_ff <= 1'b1;
               if (hold_v_ff) begin
                  rsp_v_ff  <= 1'b1;
                  hold_v_ff <= 1'b0;
                  rsp_ff    <= '{out_stream: hold_sid_ff,
                                 out_key: hold_ent_ff[ENTRY_W-1 -: KEY_BITS],
                                 out_payload: hold_ent_ff[PAYLOAD_BITS-1:0],
                                 is_last: 1'b1, overflowed: ovf_ff};
               end
            end
         end
         if (state_ff == ST_POP) begin
            hold_v_ff   <= 1'b1;
            hold_sid_ff <= pop_sid_ff;
            hold_ent_ff <= ram_q;
         end
      end
   end

   // read the popped stream's next head during the pop cycle; the following
   // evaluation uses it from the RAM output and stores it into the key register
   assign head_slot = SLOT_W'(pop_sid_ff) * SLOT_W'(FIFO_DEPTH) + SLOT_W'(rdp_ff[pop_sid_ff]);

   kwm_ram #(.WIDTH(ENTRY_W), .DEPTH(NUM_STREAMS * FIFO_DEPTH)) u_heads (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (wr_slot),
      .wr_data ({req.data.order_key[KEY_BITS-1:0], req.data.payload[PAYLOAD_BITS-1:0]}),
      .rd_addr (head_slot),
      .rd_data (head_q)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         refresh_ff <= 1'b0;
      end else begin
         refresh_ff     <= (state_ff == ST_POP) && (fill_ff[pop_sid_ff] != '0);
         refresh_sid_ff <= pop_sid_ff;
      end
   end

`ifndef ASSERT_OFF
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      state_ff != ST_IDLE |-> !req.ready) else $error("accept while busy");
   a_pop_after_eval: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_POP |-> $past(state_ff) == ST_EVAL) else $error("stray pop");
   a_fin_sticky: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) && $past(fin_ff) |-> fin_ff) else $error("finish cleared");
   a_ovf_sticky: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) && $past(ovf_ff) |-> ovf_ff) else $error("overflow cleared");
`endif
endmodule
`default_nettype wire

// File: dv/tb.sv
// Self-checking bench for k_way_sorted_stream_merge: random sorted streams,
// bursty sender, stalling receiver, in-bench merge predictor.
// Depends on kwm_pkg, kwm_req_if / kwm_rsp_if and the merge RTL.
`timescale 1ns / 100ps
module tb;
   import kwm_pkg::*;

   localparam int CLK_HALF    = 6;
   localparam int CYCLE_LIMIT = 300000;
   localparam int SETTLE      = 60;    // idle cycles before a register write
   localparam int PHASE_ITEMS = 50;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       csr_wr_en = 1'b0;
   logic [3:0] csr_wr_data = 4'd0;

   kwm_req_if req_if ();
   kwm_rsp_if rsp_if ();

   k_way_sorted_stream_merge uut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req         (req_if),
      .rsp         (rsp_if)
   );

   always #(CLK_HALF) clock = ~clock;

   // ---------------------------------------------------------------------
   // Merge predictor: per-stream FIFOs, end flags, hold stage, sticky flags
   // ---------------------------------------------------------------------
   logic [KEY_BITS-1:0]     fifo_key [NUM_STREAMS][FIFO_DEPTH];
   logic [PAYLOAD_BITS-1:0] fifo_pay [NUM_STREAMS][FIFO_DEPTH];
   int                      fifo_fill [NUM_STREAMS];
   int                      fifo_rd [NUM_STREAMS];
   int                      fifo_wr [NUM_STREAMS];
   bit                      stream_ended [NUM_STREAMS];
   bit                      drop_seen;
   bit                      merge_done;
   logic [3:0]              active_cfg;
   bit                      held_valid;
   rsp_type                 held_elem;
   rsp_type                 merged_order [$];   // results still owed by the block
   int                      error_count;

   task automatic release_held(input bit final_elem);
      rsp_type r;
      r = held_elem;
      r.is_last = final_elem;
      r.overflowed = drop_seen;
      merged_order = {merged_order, r};
   endtask

   task automatic merge_predict(input req_type r);
      int  lim;
      int  sid;
      int  emitted;
      int  best;
      bit  blocked;
      bit  found;
      logic [KEY_BITS-1:0] best_key;
      emitted = 0;
      if (merge_done)
         return;
      lim = (active_cfg < 1) ? 1 : ((active_cfg > NUM_STREAMS) ? NUM_STREAMS : active_cfg);
      sid = r.stream_id;
      // Take in the request: end marker, drop on full, or push.
      if (sid < lim && !stream_ended[sid]) begin
         if (r.end_of_stream)
            stream_ended[sid] = 1'b1;
         else if (fifo_fill[sid] >= FIFO_DEPTH)
            drop_seen = 1'b1;
         else begin
            fifo_key[sid][fifo_wr[sid]] = r.order_key;
            fifo_pay[sid][fifo_wr[sid]] = r.payload;
            fifo_wr[sid] = (fifo_wr[sid] + 1) % FIFO_DEPTH;
            fifo_fill[sid]++;
         end
      end
      // Drain while every live, unfinished stream has a head.
      while (emitted < 32) begin
         blocked = 1'b0;
         found = 1'b0;
         best = 0;
         best_key = '0;
         for (int s = 0; s < lim; s++)
            if (!stream_ended[s] && fifo_fill[s] == 0)
               blocked = 1'b1;
         if (blocked)
            break;
         // Strict less-than keeps ties on the lower stream number.
         for (int s = 0; s < lim; s++)
            if (fifo_fill[s] > 0 && (!found || fifo_key[s][fifo_rd[s]] < best_key)) begin
               found = 1'b1;
               best = s;
               best_key = fifo_key[s][fifo_rd[s]];
            end
         if (!found) begin
            // Everything ended and empty: flush the held element as the last one.
            if (held_valid) begin
               release_held(1'b1);
               held_valid = 1'b0;
            end
            merge_done = 1'b1;
            break;
         end
         if (held_valid) begin
            release_held(1'b0);
            emitted++;
         end
         held_valid = 1'b1;
         held_elem.out_stream = best[2:0];
         held_elem.out_key = fifo_key[best][fifo_rd[best]];
         held_elem.out_payload = fifo_pay[best][fifo_rd[best]];
         fifo_rd[best] = (fifo_rd[best] + 1) % FIFO_DEPTH;
         fifo_fill[best]--;
      end
   endtask

   // ---------------------------------------------------------------------
   // Monitor: sample handshakes at the rising edge, feed the predictor,
   // check each result against the oldest expectation.
   // ---------------------------------------------------------------------
   bit req_taken;
   int cycle_count;

   always @(posedge clock) begin
      rsp_type got;
      rsp_type want;
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end else if (!reset) begin
         if (csr_wr_en)
            active_cfg = csr_wr_data;
         if (req_if.valid && req_if.ready) begin
            merge_predict(req_if.data);
            req_taken = 1'b1;
         end
         if (rsp_if.valid && rsp_if.ready) begin
            got = rsp_if.data;
            if (merged_order.size() == 0) begin
               $display("%0t: unexpected result, expected none, actual %p", $time, got);
               error_count++;
            end else begin
               want = merged_order.pop_front();
               if (got.out_stream !== want.out_stream) begin
                  $display("%0t: out_stream expected %0d actual %0d", $time,
                           want.out_stream, got.out_stream);
                  error_count++;
               end
               if (got.out_key !== want.out_key) begin
                  $display("%0t: out_key expected %h actual %h", $time,
                           want.out_key, got.out_key);
                  error_count++;
               end
               if (got.out_payload !== want.out_payload) begin
                  $display("%0t: out_payload expected %h actual %h", $time,
                           want.out_payload, got.out_payload);
                  error_count++;
               end
               if (got.is_last !== want.is_last) begin
                  $display("%0t: is_last expected %b actual %b", $time,
                           want.is_last, got.is_last);
                  error_count++;
               end
               if (got.overflowed !== want.overflowed) begin
                  $display("%0t: overflowed expected %b actual %b", $time,
                           want.overflowed, got.overflowed);
                  error_count++;
               end
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // Driver: bursts of requests with random gaps, fed from a queue.
   // Hold a request until it is taken; change inputs on the falling edge.
   // ---------------------------------------------------------------------
   req_type pending_reqs [$];
   int      burst_left;
   int      gap_left;

   initial begin
      req_if.valid = 1'b0;
      req_if.data = '0;
      rsp_if.ready = 1'b0;
   end

   always @(negedge clock) begin
      if (!reset && !(req_if.valid && !req_taken)) begin
         req_taken = 1'b0;
         if (gap_left > 0) begin
            gap_left--;
            req_if.valid <= 1'b0;
         end else if (pending_reqs.size() > 0) begin
            req_if.data <= pending_reqs.pop_front();
            req_if.valid <= 1'b1;
            if (burst_left == 0) begin
               // Close the burst: sometimes run straight on, else rest a while.
               burst_left = $urandom_range(1, 24);
               gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 9);
            end else
               burst_left--;
         end else
            req_if.valid <= 1'b0;
      end
   end

   // ---------------------------------------------------------------------
   // Receiver: stall pattern that rotates through four modes, plus one
   // long hold-off on request from the stimulus.
   // ---------------------------------------------------------------------
   bit long_hold_req;
   int hold_left;
   int ready_cycle;

   always @(negedge clock) begin
      int mode;
      ready_cycle++;
      mode = (ready_cycle / 64) % 4;
      if (long_hold_req) begin
         long_hold_req = 1'b0;
         hold_left = 400;
      end
      if (reset)
         rsp_if.ready <= 1'b0;
      else if (hold_left > 0) begin
         hold_left--;
         rsp_if.ready <= 1'b0;
      end else
         case (mode)
            0: rsp_if.ready <= 1'b1;
            1: rsp_if.ready <= 1'($urandom_range(0, 1));
            2: rsp_if.ready <= (ready_cycle % 4 == 0);
            default: rsp_if.ready <= ($urandom_range(0, 9) != 0);
         endcase
   end

   // ---------------------------------------------------------------------
   // Stimulus
   // ---------------------------------------------------------------------
   logic [KEY_BITS-1:0] last_key [NUM_STREAMS];

   task automatic wait_drained();
      while (pending_reqs.size() > 0 || req_if.valid || merged_order.size() > 0)
         @(posedge clock);
   endtask

   // Write active_streams only once the block has gone quiet.
   task automatic write_active(input logic [3:0] value);
      wait_drained();
      repeat (SETTLE) @(posedge clock);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic push_req(input int sid, input bit eos, input logic [KEY_BITS-1:0] key,
                           input logic [PAYLOAD_BITS-1:0] pay);
      req_type r;
      r.stream_id = sid[2:0];
      r.end_of_stream = eos;
      r.order_key = key;
      r.payload = pay;
      pending_reqs = {pending_reqs, r};
   endtask

   // Next element of a stream, keys ascending (equal keys allowed).
   task automatic push_element(input int sid);
      logic [KEY_BITS-1:0] step;
      case ($urandom_range(0, 3))
         0: step = '0;
         1: step = 64'($urandom_range(1, 100));
         default: step = {32'd0, $urandom} << $urandom_range(0, 24);
      endcase
      if (last_key[sid][63:58] != 0)
         step = '0;
      last_key[sid] = last_key[sid] + step;
      push_req(sid, 1'b0, last_key[sid], $urandom);
   endtask

   function automatic int clamp_active(input logic [3:0] v);
      return (v < 1) ? 1 : ((v > NUM_STREAMS) ? NUM_STREAMS : v);
   endfunction

   initial begin
      logic [3:0] phase_cfg [6];
      int         lim;
      int         order [NUM_STREAMS];
      int         tmp;
      int         j;
      phase_cfg = '{4'd1, 4'd0, 4'd5, 4'd3, 4'd8, 4'd15};
      active_cfg = 4'd8;
      for (int s = 0; s < NUM_STREAMS; s++) begin
         fifo_fill[s] = 0;
         fifo_rd[s] = 0;
         fifo_wr[s] = 0;
         stream_ended[s] = 1'b0;
         last_key[s] = '0;
      end
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: key zero on every stream with extreme payloads (ties go
      // to the lower stream), then flood stream 2 until it drops.
      for (int s = 0; s < NUM_STREAMS; s++)
         push_req(s, 1'b0, '0, (s % 2) ? '1 : '0);
      for (int n = 0; n < 7; n++)
         push_element(2);
      push_element(5);

      // Random phases at several widths; no stream ends until the last one.
      foreach (phase_cfg[p]) begin
         write_active(phase_cfg[p]);
         lim = clamp_active(phase_cfg[p]);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if (p == 2 && n == 25)
               wait_drained();                  // sender pauses until all results are in
            if (p == 3 && n == 5)
               long_hold_req = 1'b1;            // receiver holds off; sender keeps going
            if (lim < NUM_STREAMS && $urandom_range(0, 6) == 0)
               push_req($urandom_range(lim, NUM_STREAMS - 1), 1'($urandom_range(0, 1)),
                        {$urandom, $urandom}, $urandom);   // stream not taking part
            else
               push_element($urandom_range(0, lim - 1));
         end
      end

      // Final phase at active 15 (clamped to all streams): end each stream
      // in random order, topping it with the largest key, with an element
      // after the end and a repeated end marker thrown in.
      for (int s = 0; s < NUM_STREAMS; s++)
         order[s] = s;
      for (int s = NUM_STREAMS - 1; s > 0; s--) begin
         j = $urandom_range(0, s);
         tmp = order[s];
         order[s] = order[j];
         order[j] = tmp;
      end
      for (int s = 0; s < NUM_STREAMS; s++) begin
         for (int n = 0; n < 3; n++)
            push_element($urandom_range(0, NUM_STREAMS - 1));
         if (stream_is_open(order, s))
            push_req(order[s], 1'b0, '1, $urandom);
         push_req(order[s], 1'b1, {$urandom, $urandom}, $urandom);
         push_req(order[s], 1'b0, '0, $urandom);
         push_req(order[s], 1'b1, '0, '0);
      end
      // Merge finished: everything after is ignored.
      for (int n = 0; n < 4; n++)
         push_req($urandom_range(0, NUM_STREAMS - 1), 1'b0, {$urandom, $urandom}, $urandom);

      wait_drained();
      repeat (SETTLE) @(posedge clock);
      if (error_count == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

   // Streams already ended in this final pass must not receive further
   // ascending keys, so only top up the one about to end.
   function automatic bit stream_is_open(input int order [NUM_STREAMS], input int idx);
      for (int k = 0; k < idx; k++)
         if (order[k] == order[idx])
            return 1'b0;
      return 1'b1;
   endfunction
endmodule
